### hw/rtl/srvseq_pkg.sv
`default_nettype none

package srvseq_pkg;

    // channel count, 1..8
    localparam int CHANNELS        = 4;
    localparam int MAX_CHANNELS    = 8;
    localparam int POSITION_FIELDS = 4;

    localparam int POS_W   = 8;
    localparam int BASE_W  = 12;
    localparam int STEP_W  = 6;
    localparam int SLOT_W  = 14;
    localparam int FRAME_W = 16;
    localparam int HB_W    = 20;
    localparam int LINES_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int PROD_W  = STEP_W + POS_W;
    localparam int WIDTH_W = PROD_W + 1;
    localparam int START_W = SLOT_W + 3;

    localparam logic [BASE_W-1:0]  PULSE_BASE_RST   = BASE_W'(1000);
    localparam logic [STEP_W-1:0]  PULSE_STEP_RST   = STEP_W'(10);
    localparam logic [SLOT_W-1:0]  SLOT_LEN_RST     = SLOT_W'(2500);
    localparam logic [FRAME_W-1:0] FRAME_LEN_RST    = FRAME_W'(20000);
    localparam logic [HB_W-1:0]    HB_ON_RST        = HB_W'(50000);
    localparam logic [HB_W-1:0]    HB_PERIOD_RST    = HB_W'(500000);
    localparam logic [POS_W-1:0]   POS_EVEN_RST     = POS_W'(50);
    localparam logic [POS_W-1:0]   POS_ODD_RST      = POS_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_BASE = 3'd0,
        REG_PULSE_STEP = 3'd1,
        REG_SLOT_LEN   = 3'd2,
        REG_FRAME_LEN  = 3'd3,
        REG_HB_ON      = 3'd4,
        REG_HB_PERIOD  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

endpackage

`default_nettype wire

### hw/rtl/four_channel_servo_pulse_sequencer.sv
// Servo pulse sequencer: each request is either a 1 us tick (action = 0) or a
// write of four channel positions (action = 1), and each request yields exactly
// one result with the servo and heartbeat line levels after it is applied.
// Channel k rises at k * slot_length_us in the frame and stays high for
// pulse_base_us + pulse_step_us * position, clamped to the slot length.
// One request is taken every clock while results are taken as fast; a result is
// presented once its request is accepted and the output register is free: the
// accepting edge updates the counters and positions, a later edge registers the
// line levels decoded from them in the output register. A stalled result holds
// back at most one more request.
// Configuration writes are taken at any time (cfg_ready is tied high) but must
// only be issued while no request is in flight.
`default_nettype none

module four_channel_servo_pulse_sequencer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [srvseq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srvseq_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              action,
    input  wire logic [srvseq_pkg::POS_W-1:0]      position_a,
    input  wire logic [srvseq_pkg::POS_W-1:0]      position_b,
    input  wire logic [srvseq_pkg::POS_W-1:0]      position_c,
    input  wire logic [srvseq_pkg::POS_W-1:0]      position_d,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [srvseq_pkg::LINES_W-1:0]         servo_lines,
    output logic                                   heartbeat_line
);

    localparam int CH      = srvseq_pkg::CHANNELS;
    localparam int POS_W   = srvseq_pkg::POS_W;
    localparam int FRAME_W = srvseq_pkg::FRAME_W;
    localparam int HB_W    = srvseq_pkg::HB_W;
    localparam int WIDTH_W = srvseq_pkg::WIDTH_W;
    localparam int START_W = srvseq_pkg::START_W;
    localparam int PROD_W  = srvseq_pkg::PROD_W;

    // configuration registers
    logic [srvseq_pkg::BASE_W-1:0]  pulse_base_reg;
    logic [srvseq_pkg::STEP_W-1:0]  pulse_step_reg;
    logic [srvseq_pkg::SLOT_W-1:0]  slot_len_reg;
    logic [FRAME_W-1:0]             frame_len_reg;
    logic [HB_W-1:0]                hb_on_reg;
    logic [HB_W-1:0]                hb_period_reg;

    // state
    logic [FRAME_W-1:0] frame_time_reg, frame_time_next;
    logic [HB_W-1:0]    hb_time_reg, hb_time_next;
    logic [POS_W-1:0]   pos_reg [CH];
    logic [POS_W-1:0]   pos_in  [srvseq_pkg::POSITION_FIELDS];

    // pipeline control
    logic               pend_reg;
    logic               out_valid_reg;
    logic [srvseq_pkg::LINES_W-1:0] servo_lines_reg, servo_lines_next;
    logic               heartbeat_line_reg, heartbeat_line_next;

    logic               in_fire;
    logic               out_load;
    logic               tick;
    logic               wr_pos;
    logic [FRAME_W:0]   frame_inc;
    logic [HB_W:0]      hb_inc;
    logic [CH-1:0]      chan_hit;
    logic [srvseq_pkg::MAX_CHANNELS-1:0] hit_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_base_reg <= srvseq_pkg::PULSE_BASE_RST;
            pulse_step_reg <= srvseq_pkg::PULSE_STEP_RST;
            slot_len_reg   <= srvseq_pkg::SLOT_LEN_RST;
            frame_len_reg  <= srvseq_pkg::FRAME_LEN_RST;
            hb_on_reg      <= srvseq_pkg::HB_ON_RST;
            hb_period_reg  <= srvseq_pkg::HB_PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            case (srvseq_pkg::cfg_reg_t'(cfg_index))
                srvseq_pkg::REG_PULSE_BASE: pulse_base_reg <= cfg_data[srvseq_pkg::BASE_W-1:0];
                srvseq_pkg::REG_PULSE_STEP: pulse_step_reg <= cfg_data[srvseq_pkg::STEP_W-1:0];
                srvseq_pkg::REG_SLOT_LEN:   slot_len_reg   <= cfg_data[srvseq_pkg::SLOT_W-1:0];
                srvseq_pkg::REG_FRAME_LEN:  frame_len_reg  <= cfg_data[FRAME_W-1:0];
                srvseq_pkg::REG_HB_ON:      hb_on_reg      <= cfg_data[HB_W-1:0];
                srvseq_pkg::REG_HB_PERIOD:  hb_period_reg  <= cfg_data[HB_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the pending stage moves into the output register when it is free
    assign out_load = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || out_load;
    assign in_fire  = in_valid && in_ready;
    assign tick     = in_fire && (srvseq_pkg::action_t'(action) == srvseq_pkg::ACT_TICK);
    assign wr_pos   = in_fire && (srvseq_pkg::action_t'(action) == srvseq_pkg::ACT_WRITE);

    // wrapping counters; a counter above a shortened length wraps on the next tick
    always_comb
    begin
        frame_inc = {1'b0, frame_time_reg} + (FRAME_W+1)'(1);
        hb_inc    = {1'b0, hb_time_reg} + (HB_W+1)'(1);
        frame_time_next = (frame_inc >= {1'b0, frame_len_reg}) ? '0 : frame_inc[FRAME_W-1:0];
        hb_time_next    = (hb_inc >= {1'b0, hb_period_reg}) ? '0 : hb_inc[HB_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= '0;
            hb_time_reg    <= '0;
        end
        else if (tick)
        begin
            frame_time_reg <= frame_time_next;
            hb_time_reg    <= hb_time_next;
        end
    end

    assign pos_in[0] = position_a;
    assign pos_in[1] = position_b;
    assign pos_in[2] = position_c;
    assign pos_in[3] = position_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CH; k++)
                pos_reg[k] <= ((k & 1) == 0) ? srvseq_pkg::POS_EVEN_RST
                                             : srvseq_pkg::POS_ODD_RST;
        end
        else if (wr_pos)
        begin
            // channels without a position field keep their reset value
            for (int k = 0; k < CH && k < srvseq_pkg::POSITION_FIELDS; k++)
                pos_reg[k] <= pos_in[k];
        end
    end

    for (genvar k = 0; k < CH; k++)
    begin : g_chan
        logic [PROD_W-1:0]  prod;
        logic [WIDTH_W-1:0] width_raw;
        logic [WIDTH_W-1:0] width_clamp;
        logic [START_W-1:0] start;
        logic [START_W-1:0] diff;
        logic               hit;

        always_comb
        begin
            prod        = PROD_W'(pulse_step_reg) * PROD_W'(pos_reg[k]);
            width_raw   = WIDTH_W'(pulse_base_reg) + WIDTH_W'(prod);
            width_clamp = (width_raw > WIDTH_W'(slot_len_reg)) ? WIDTH_W'(slot_len_reg)
                                                                : width_raw;
            start       = START_W'(k) * START_W'(slot_len_reg);
            diff        = START_W'(frame_time_reg) - start;
            hit         = (START_W'(frame_time_reg) >= start) &&
                          (diff < START_W'(width_clamp));
        end

        assign chan_hit[k] = hit;
    end

    always_comb
    begin
        hit_ext             = srvseq_pkg::MAX_CHANNELS'(chan_hit);
        servo_lines_next    = hit_ext[srvseq_pkg::LINES_W-1:0];
        heartbeat_line_next = (hb_time_reg < hb_on_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                pend_reg <= 1'b1;
            else if (out_load)
                pend_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            servo_lines_reg    <= servo_lines_next;
            heartbeat_line_reg <= heartbeat_line_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign servo_lines    = servo_lines_reg;
    assign heartbeat_line = heartbeat_line_reg;

endmodule

`default_nettype wire

### hw/rtl/srvseq_checker.sv
`default_nettype none

module srvseq_props (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [srvseq_pkg::LINES_W-1:0]    servo_lines,
    input wire logic                              heartbeat_line
);

    // a stalled result holds its levels
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(servo_lines) && $stable(heartbeat_line))
        else $error("result changed while stalled");

    // every accepted request must be followed by a result with out_valid high
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("result missing after accepted request");

    // with the output register empty nothing can block the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind four_channel_servo_pulse_sequencer srvseq_props u_srvseq_props (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .servo_lines    (servo_lines),
    .heartbeat_line (heartbeat_line)
);

`default_nettype wire
